>>> hw/rtl/srl_pkg.sv
// srl_pkg: types and status codes shared by the square region lock table
// depends on: nothing
`timescale 1ns / 1ps
`default_nettype none

package srl_pkg;

    localparam int CoordW  = 32;
    localparam int RadiusW = 16;
    localparam int StoredRadiusW = 15;
    localparam int StatusW = 3;
    localparam int SlotW   = 4;
    localparam int SlotReachMax = 16;

    localparam logic KIND_ACQUIRE = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    localparam logic [StatusW-1:0] ST_GRANTED   = 3'd0;
    localparam logic [StatusW-1:0] ST_CONFLICT  = 3'd1;
    localparam logic [StatusW-1:0] ST_NEG_RAD   = 3'd2;
    localparam logic [StatusW-1:0] ST_RANGE     = 3'd3;
    localparam logic [StatusW-1:0] ST_FULL      = 3'd4;
    localparam logic [StatusW-1:0] ST_EMPTY     = 3'd5;
    localparam logic [StatusW-1:0] ST_RELEASED  = 3'd6;

    typedef struct packed {
        logic                       kind;
        logic signed [CoordW-1:0]   center_x;
        logic signed [CoordW-1:0]   center_z;
        logic signed [RadiusW-1:0]  radius;
        logic [SlotW-1:0]           release_slot;
    } srl_req_t;

    typedef struct packed {
        logic [StatusW-1:0] status;
        logic [SlotW-1:0]   slot;
    } srl_rsp_t;

    // one held square as kept in the entry memory
    typedef struct packed {
        logic signed [CoordW-1:0]  center_x;
        logic signed [CoordW-1:0]  center_z;
        logic [StoredRadiusW-1:0]  radius;
    } srl_entry_t;

endpackage

`default_nettype wire

>>> hw/rtl/srl_stream_if.sv
// srl_stream_if: valid/ready channel carrying one payload per transaction
// depends on: nothing (payload type given by the instantiating code)
`timescale 1ns / 1ps
`default_nettype none

interface srl_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/srl_overlap.sv
// srl_overlap: overlap test of one stored square against the request square
// depends on: srl_pkg
`timescale 1ns / 1ps
`default_nettype none

module srl_overlap (
    input  wire srl_pkg::srl_entry_t                        entry,
    input  wire logic signed [srl_pkg::CoordW-1:0]          center_x,
    input  wire logic signed [srl_pkg::CoordW-1:0]          center_z,
    input  wire logic [srl_pkg::StoredRadiusW-1:0]          radius,
    output logic                                            hit
);
    import srl_pkg::*;

    localparam int DiffW = CoordW + 1;

    logic signed [DiffW-1:0]   dx_a;
    logic signed [DiffW-1:0]   dx_b;
    logic signed [DiffW-1:0]   dz_a;
    logic signed [DiffW-1:0]   dz_b;
    logic [DiffW-1:0]          abs_dx;
    logic [DiffW-1:0]          abs_dz;
    logic [StoredRadiusW:0]    sum_r;

    // both directions in parallel, keep the non-negative one
    always_comb
    begin
        dx_a   = DiffW'(entry.center_x) - DiffW'(center_x);
        dx_b   = DiffW'(center_x) - DiffW'(entry.center_x);
        dz_a   = DiffW'(entry.center_z) - DiffW'(center_z);
        dz_b   = DiffW'(center_z) - DiffW'(entry.center_z);
        abs_dx = dx_a[DiffW-1] ? dx_b : dx_a;
        abs_dz = dz_a[DiffW-1] ? dz_b : dz_a;
        sum_r  = (StoredRadiusW+1)'(entry.radius) + (StoredRadiusW+1)'(radius);
        hit    = (abs_dx <= DiffW'(sum_r)) && (abs_dz <= DiffW'(sum_r));
    end

endmodule

`default_nettype wire

>>> hw/rtl/square_region_lock_table.sv
// square_region_lock_table: lock table for square neighbourhoods on a 2d grid
// depends on: srl_pkg, srl_stream_if, srl_overlap
//
// usage
//   req (sink) carries one acquire or release transaction; rsp (source)
//   returns exactly one status/slot transaction for each request, in order.
//   an acquire is checked for a negative radius, then for the square leaving
//   the signed 32-bit range, then against every held square, then for a free
//   slot (lowest of slots 0..15 that exist). a release frees the named slot.
// timing
//   one request at a time. a release goes from acceptance through the decide
//   and done steps to the result register; an acquire that passes the radius
//   and range checks walks the entry memory one entry a cycle, then drains
//   the compare stage and decides before it reaches done. the single read
//   port of the entry memory sets the length of that walk; errors found
//   early go from the check step straight to done.
// reset
//   rst_n clears all valid bits at once (no locks held) and empties the
//   result register. the entry memory itself is not cleared: an entry is
//   only looked at while its valid bit is set.
// stalls
//   the result sits in an output register; the next request is accepted
//   while it waits. a finished result waits in its last step until the
//   output register frees up, and no table update happens before that.
`timescale 1ns / 1ps
`default_nettype none

module square_region_lock_table #(
    parameter int ENTRIES = 16
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    srl_stream_if.sink   req,
    srl_stream_if.source rsp
);
    import srl_pkg::*;

    localparam int IdxW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int Reach = (ENTRIES < SlotReachMax) ? ENTRIES : SlotReachMax;
    localparam int ExtW  = CoordW + 2;

    // sequencer codes
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_DECIDE = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]             state_reg, state_next;
    srl_req_t               req_reg;
    logic [ENTRIES-1:0]     valid_reg;
    logic [IdxW-1:0]        scan_idx_reg;
    logic [IdxW-1:0]        cmp_idx_reg;
    logic                   cmp_vld_reg;
    logic                   conflict_reg;
    logic [StatusW-1:0]     res_status_reg;
    logic [SlotW-1:0]       res_slot_reg;
    logic                   rsp_valid_reg;
    srl_rsp_t               rsp_payload_reg;

    // entry memory, one read and one write port, registered read data
    srl_entry_t             entry_mem [ENTRIES];
    srl_entry_t             rd_data_reg;
    srl_entry_t             wr_data;
    logic [IdxW-1:0]        wr_addr;
    logic                   mem_we;

    logic                   req_fire;
    logic                   commit;
    logic                   hit;
    logic [31:0]            rel_ext;
    logic                   rel_in_table;
    logic [IdxW-1:0]        rel_idx;
    logic [SlotW-1:0]       free_slot;
    logic                   free_found;
    logic [ExtW-1:0]        x_lo, x_hi, z_lo, z_hi;
    logic                   edge_overflow;

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign commit    = (state_reg == S_DONE) && (!rsp_valid_reg || rsp.ready);

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_payload_reg;

    // release slot decode: slots beyond the table count as empty
    always_comb
    begin
        rel_ext      = 32'(req_reg.release_slot);
        rel_in_table = rel_ext < 32'(ENTRIES);
        rel_idx      = rel_ext[IdxW-1:0];
    end

    // square edges, two guard bits; outside 32-bit when the top three differ
    always_comb
    begin
        x_lo = ExtW'(req_reg.center_x) - ExtW'(req_reg.radius);
        x_hi = ExtW'(req_reg.center_x) + ExtW'(req_reg.radius);
        z_lo = ExtW'(req_reg.center_z) - ExtW'(req_reg.radius);
        z_hi = ExtW'(req_reg.center_z) + ExtW'(req_reg.radius);
        edge_overflow = (x_lo[ExtW-1:CoordW-1] != 3'b000 && x_lo[ExtW-1:CoordW-1] != 3'b111)
                     || (x_hi[ExtW-1:CoordW-1] != 3'b000 && x_hi[ExtW-1:CoordW-1] != 3'b111)
                     || (z_lo[ExtW-1:CoordW-1] != 3'b000 && z_lo[ExtW-1:CoordW-1] != 3'b111)
                     || (z_hi[ExtW-1:CoordW-1] != 3'b000 && z_hi[ExtW-1:CoordW-1] != 3'b111);
    end

    // lowest free slot among those a 4-bit slot field can name
    always_comb
    begin
        free_slot  = '0;
        free_found = 1'b0;
        for (int i = Reach - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_slot  = SlotW'(i);
                free_found = 1'b1;
            end
        end
    end

    srl_overlap u_overlap (
        .entry    (rd_data_reg),
        .center_x (req_reg.center_x),
        .center_z (req_reg.center_z),
        .radius   (req_reg.radius[StoredRadiusW-1:0]),
        .hit      (hit)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = (req.payload.kind == KIND_RELEASE) ? S_DECIDE : S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (req_reg.radius[RadiusW-1] || edge_overflow)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (32'(scan_idx_reg) == 32'(ENTRIES - 1))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:  state_next = S_DECIDE;
            S_DECIDE: state_next = S_DONE;
            S_DONE:
            begin
                if (commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            scan_idx_reg  <= '0;
            cmp_vld_reg   <= 1'b0;
            conflict_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cmp_vld_reg <= (state_reg == S_SCAN);

            if (state_reg == S_CHECK)
            begin
                scan_idx_reg <= '0;
                conflict_reg <= 1'b0;
            end
            else if (state_reg == S_SCAN)
            begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end

            // compare stage: data of the entry read in the previous cycle
            if (cmp_vld_reg && valid_reg[cmp_idx_reg] && hit)
            begin
                conflict_reg <= 1'b1;
            end

            if (commit)
            begin
                rsp_valid_reg <= 1'b1;
                if (req_reg.kind == KIND_RELEASE && res_status_reg == ST_RELEASED)
                begin
                    valid_reg[rel_idx] <= 1'b0;
                end
                else if (req_reg.kind == KIND_ACQUIRE && res_status_reg == ST_GRANTED)
                begin
                    valid_reg[wr_addr] <= 1'b1;
                end
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= scan_idx_reg;
        if (req_fire)
        begin
            req_reg <= req.payload;
        end

        unique case (state_reg)
            S_CHECK:
            begin
                res_slot_reg <= '0;
                if (req_reg.radius[RadiusW-1])
                begin
                    res_status_reg <= ST_NEG_RAD;
                end
                else
                begin
                    res_status_reg <= ST_RANGE;
                end
            end
            S_DECIDE:
            begin
                if (req_reg.kind == KIND_RELEASE)
                begin
                    res_slot_reg   <= req_reg.release_slot;
                    res_status_reg <= (rel_in_table && valid_reg[rel_idx]) ? ST_RELEASED
                                                                             : ST_EMPTY;
                end
                else if (conflict_reg)
                begin
                    res_slot_reg   <= '0;
                    res_status_reg <= ST_CONFLICT;
                end
                else if (free_found)
                begin
                    res_slot_reg   <= free_slot;
                    res_status_reg <= ST_GRANTED;
                end
                else
                begin
                    res_slot_reg   <= '0;
                    res_status_reg <= ST_FULL;
                end
            end
            default:
            begin
            end
        endcase

        if (commit)
        begin
            rsp_payload_reg.status <= res_status_reg;
            rsp_payload_reg.slot   <= res_slot_reg;
        end
    end

    // table write on a grant, at the same edge the result is handed over
    always_comb
    begin
        wr_addr          = IdxW'(32'(res_slot_reg));
        wr_data.center_x = req_reg.center_x;
        wr_data.center_z = req_reg.center_z;
        wr_data.radius   = req_reg.radius[StoredRadiusW-1:0];
        mem_we           = commit && (req_reg.kind == KIND_ACQUIRE)
                           && (res_status_reg == ST_GRANTED);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= entry_mem[scan_idx_reg];
    end

endmodule

`default_nettype wire
